// ===== rtl/phf_pkg.sv =====
// ----------------------------------------------------------------------------
// phf_pkg: shared types and constants for the point hash find-or-insert block
// Widths, golden-ratio multiplier, controller states and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package phf_pkg;

   localparam int CAPACITY     = 1024;
   localparam int MAX_BUCKETS  = 1024;
   localparam int BUCKET_RESET = 1024;

   localparam int COORD_W = 32;
   localparam int CSR_W   = 11;
   localparam int OUT_IDX_W = 10;
   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int LINK_W  = $clog2(CAPACITY + 1);
   localparam int BKT_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int BPROD_W = 32 + CSR_W;

   localparam int BCNT_RESET = (BUCKET_RESET > MAX_BUCKETS) ? MAX_BUCKETS : BUCKET_RESET;

   // floor(((sqrt(5)-1)/2) * 2^32)
   localparam logic [31:0] GOLDEN_Q32 = 32'h9E37_79B9;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [CSR_W-1:0]          bcnt_type;
   typedef logic [OUT_IDX_W-1:0]      out_idx_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [LINK_W-1:0]         link_type;
   typedef logic [BKT_W-1:0]          bkt_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_KEY,
      ST_PAIR,
      ST_MIX,
      ST_BUCKET,
      ST_HEAD,
      ST_LINK,
      ST_CHECK,
      ST_CMP,
      ST_INSERT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RES_FOUND,
      RES_NEW,
      RES_FULL
   } res_type;

   typedef struct packed {
      logic    req_ready;
      logic    clr_wr;
      logic    load_in;
      logic    st_key;
      logic    st_pair;
      logic    st_mix;
      logic    st_bucket;
      logic    load_link_head;
      logic    load_link_next;
      logic    insert;
      logic    set_res;
      res_type res_sel;
      logic    load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic link_zero;
      logic match;
      logic full;
      logic rsp_busy;
   } stat_type;

endpackage

// ===== rtl/phf_if.sv =====
// ----------------------------------------------------------------------------
// phf_if: channel interfaces
// Request, response and CSR write channels, each valid/ready with payload.
// ----------------------------------------------------------------------------
interface phf_req_if import phf_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type x_coord;
   coord_type y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface phf_rsp_if import phf_pkg::*; ();
   logic        valid;
   logic        ready;
   out_idx_type entry_index;
   logic        found;
   logic        full_res;

   modport source (output valid, output entry_index, output found, output full_res,
                   input ready);
   modport sink   (input valid, input entry_index, input found, input full_res,
                   output ready);
endinterface

interface phf_csr_if import phf_pkg::*; ();
   logic     valid;
   logic     ready;
   bcnt_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/phf_ctrl.sv =====
// ----------------------------------------------------------------------------
// phf_ctrl: sequencing controller
// Clears bucket heads after reset, then steps each transaction through
// hashing, head lookup, chain walk and, on a miss with room left, insert.
// ----------------------------------------------------------------------------
module phf_ctrl import phf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_KEY;
         end
         ST_KEY:    state_in = ST_PAIR;
         ST_PAIR:   state_in = ST_MIX;
         ST_MIX:    state_in = ST_BUCKET;
         ST_BUCKET: state_in = ST_HEAD;
         ST_HEAD:   state_in = ST_LINK;
         ST_LINK:   state_in = ST_CHECK;
         ST_CHECK: begin
            if (!stat.link_zero) state_in = ST_CMP;
            else if (stat.full) state_in = ST_DONE;
            else state_in = ST_INSERT;
         end
         ST_CMP: begin
            state_in = stat.match ? ST_DONE : ST_CHECK;
         end
         ST_INSERT: state_in = ST_DONE;
         ST_DONE: begin
            if (!stat.rsp_busy) state_in = ST_IDLE;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.res_sel = RES_FOUND;
      case (state_ff)
         ST_CLEAR:  cmd.clr_wr = 1'b1;
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.load_in   = req_valid;
         end
         ST_KEY:    cmd.st_key = 1'b1;
         ST_PAIR:   cmd.st_pair = 1'b1;
         ST_MIX:    cmd.st_mix = 1'b1;
         ST_BUCKET: cmd.st_bucket = 1'b1;
         ST_HEAD:   ;
         ST_LINK:   cmd.load_link_head = 1'b1;
         ST_CHECK: begin
            if (stat.link_zero && stat.full) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_FULL;
            end
         end
         ST_CMP: begin
            if (stat.match) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_FOUND;
            end else begin
               cmd.load_link_next = 1'b1;
            end
         end
         ST_INSERT: begin
            cmd.insert  = 1'b1;
            cmd.set_res = 1'b1;
            cmd.res_sel = RES_NEW;
         end
         ST_DONE:   cmd.load_rsp = !stat.rsp_busy;
         default:   ;
      endcase
   end

endmodule

// ===== rtl/phf_dpath.sv =====
// ----------------------------------------------------------------------------
// phf_dpath: hashing datapath and table storage
// Cantor pairing, golden-ratio hash, bucket head and entry memories,
// bucket count register and the response output register.
// ----------------------------------------------------------------------------
module phf_dpath import phf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  coord_type   x_coord,
   input  coord_type   y_coord,
   input  logic        csr_valid,
   input  bcnt_type    csr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output out_idx_type rsp_entry_index,
   output logic        rsp_found,
   output logic        rsp_full_res
);

   link_type head_mem [MAX_BUCKETS];
   coord_type ex_mem [CAPACITY];
   coord_type ey_mem [CAPACITY];
   link_type en_mem [CAPACITY];

   bcnt_type    bcnt_ff;
   bkt_type     clr_cnt_ff;
   link_type    count_ff;
   coord_type   x_ff, y_ff;
   logic signed [16:0] s_ff;
   logic signed [15:0] ty_ff;
   logic [31:0] key_ff, frac_ff;
   bkt_type     bucket_ff;
   link_type    head_q_ff, link_ff;
   coord_type   ex_q_ff, ey_q_ff;
   link_type    en_q_ff;
   out_idx_type res_idx_ff;
   logic        res_found_ff, res_full_ff;
   logic        rsp_valid_ff;
   out_idx_type rsp_idx_ff;
   logic        rsp_found_ff, rsp_full_ff;

   logic signed [15:0] tx_in, ty_in;
   logic signed [16:0] s_in;
   logic signed [17:0] s1;
   logic signed [34:0] prod;
   logic [31:0]        key_in, frac_in;
   logic [BPROD_W-1:0] bprod;
   link_type           link_m1, count_p1;
   bcnt_type           bcnt_in;

   // integer part, truncated toward zero
   assign tx_in = x_ff[31:16] + {15'd0, x_ff[31] && (x_ff[15:0] != 16'd0)};
   assign ty_in = y_ff[31:16] + {15'd0, y_ff[31] && (y_ff[15:0] != 16'd0)};
   assign s_in  = {tx_in[15], tx_in} + {ty_in[15], ty_in};
   assign s1    = {s_ff[16], s_ff} + 18'sd1;
   assign prod  = s_ff * s1;
   // s*(s+1) is even; only the low 32 bits of the halved product matter
   assign key_in  = {{16{ty_ff[15]}}, ty_ff} + prod[32:1];
   assign frac_in = key_ff * GOLDEN_Q32;
   assign bprod   = BPROD_W'(frac_ff) * BPROD_W'(bcnt_ff);

   assign link_m1  = link_ff - LINK_W'(1);
   assign count_p1 = count_ff + LINK_W'(1);

   always_comb begin
      if (csr_data == '0) bcnt_in = CSR_W'(1);
      else if (32'(csr_data) > 32'(MAX_BUCKETS)) bcnt_in = CSR_W'(MAX_BUCKETS);
      else bcnt_in = csr_data;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff      <= CSR_W'(BCNT_RESET);
         clr_cnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) bcnt_ff <= bcnt_in;
         if (cmd.clr_wr) clr_cnt_ff <= clr_cnt_ff + BKT_W'(1);
         if (cmd.insert) count_ff <= count_p1;
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         x_ff <= x_coord;
         y_ff <= y_coord;
      end
      if (cmd.st_key) begin
         s_ff  <= s_in;
         ty_ff <= ty_in;
      end
      if (cmd.st_pair) key_ff <= key_in;
      if (cmd.st_mix) frac_ff <= frac_in;
      if (cmd.st_bucket) bucket_ff <= bprod[32 +: BKT_W];
      if (cmd.load_link_head) link_ff <= head_q_ff;
      else if (cmd.load_link_next) link_ff <= en_q_ff;
      if (cmd.set_res) begin
         case (cmd.res_sel)
            RES_FOUND: begin
               res_idx_ff   <= OUT_IDX_W'(link_m1);
               res_found_ff <= 1'b1;
               res_full_ff  <= 1'b0;
            end
            RES_NEW: begin
               res_idx_ff   <= OUT_IDX_W'(count_ff);
               res_found_ff <= 1'b0;
               res_full_ff  <= 1'b0;
            end
            RES_FULL: begin
               res_idx_ff   <= '0;
               res_found_ff <= 1'b0;
               res_full_ff  <= 1'b1;
            end
            default: begin
               res_idx_ff   <= '0;
               res_found_ff <= 1'b0;
               res_full_ff  <= 1'b0;
            end
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_idx_ff   <= res_idx_ff;
         rsp_found_ff <= res_found_ff;
         rsp_full_ff  <= res_full_ff;
      end
   end

   // bucket heads: link = entry index + 1, zero is an empty bucket
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) head_mem[clr_cnt_ff] <= '0;
      else if (cmd.insert) head_mem[bucket_ff] <= count_p1;
      head_q_ff <= head_mem[bucket_ff];
   end

   // entries; new entry is prepended in front of the current head
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         ex_mem[count_ff[IDX_W-1:0]] <= x_ff;
         ey_mem[count_ff[IDX_W-1:0]] <= y_ff;
         en_mem[count_ff[IDX_W-1:0]] <= head_q_ff;
      end
      ex_q_ff <= ex_mem[link_m1[IDX_W-1:0]];
      ey_q_ff <= ey_mem[link_m1[IDX_W-1:0]];
      en_q_ff <= en_mem[link_m1[IDX_W-1:0]];
   end

   assign stat.clr_last  = (clr_cnt_ff == BKT_W'(MAX_BUCKETS - 1));
   assign stat.link_zero = (link_ff == '0);
   assign stat.match     = (ex_q_ff == x_ff) && (ey_q_ff == y_ff);
   assign stat.full      = (count_ff >= LINK_W'(CAPACITY));
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_index = rsp_idx_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_full_res    = rsp_full_ff;

endmodule

// ===== rtl/point_hash_find_or_insert.sv =====
// Sequence: an accepted request steps through the key, pair, mix, bucket, head and link
//   states, then checks and compares chain entries until a hit, an insert or a full-store miss.
// Overlap: a new request is accepted only after the previous response is loaded, so
//   a response held by rsp ready also holds off the next one.
// Reset: synchronous; a pass over all bucket heads clears them, during which
//   no request is accepted. CSR writes are taken at any time.
// ----------------------------------------------------------------------------
// point_hash_find_or_insert: find-or-insert store for Q16.16 points
// Chained hash table with Cantor-pair key and golden-ratio bucket hash.
// ----------------------------------------------------------------------------
module point_hash_find_or_insert import phf_pkg::*; (
   input logic      clock,
   input logic      reset,
   phf_req_if.sink   req_ch,
   phf_rsp_if.source rsp_ch,
   phf_csr_if.sink   csr_ch
);

   cmd_type  cmd;
   stat_type stat;

   assign req_ch.ready = cmd.req_ready;
   assign csr_ch.ready = 1'b1;

   phf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   phf_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .x_coord         (req_ch.x_coord),
      .y_coord         (req_ch.y_coord),
      .csr_valid       (csr_ch.valid),
      .csr_data        (csr_ch.data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_entry_index (rsp_ch.entry_index),
      .rsp_found       (rsp_ch.found),
      .rsp_full_res    (rsp_ch.full_res)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: point hash find-or-insert testbench
// Sends Q16.16 points through the request channel and predicts each lookup
// with a private copy of the chained table: Cantor key, golden-ratio bucket,
// newest-first chain walk, insert at the next free index, full when the store
// is exhausted. Responses are checked in order. Bucket count changes between
// phases, with both channels stalling at random except in one calm phase.
// ----------------------------------------------------------------------------
module tb;
   import phf_pkg::*;

   typedef struct packed {
      out_idx_type idx;
      logic        found;
      logic        full;
   } lookup_result_type;

   typedef struct {
      coord_type x;
      coord_type y;
   } point_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm;
   int   errors;

   phf_req_if req_ch ();
   phf_rsp_if rsp_ch ();
   phf_csr_if csr_ch ();

   point_hash_find_or_insert dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // private copy of the table, links stored as index + 1 with 0 as empty
   coord_type   tbl_x    [CAPACITY];
   coord_type   tbl_y    [CAPACITY];
   int unsigned tbl_link [CAPACITY];
   int unsigned tbl_head [MAX_BUCKETS];
   int unsigned tbl_count;
   int unsigned cur_buckets = BCNT_RESET;

   lookup_result_type expected_lookups[$];
   lookup_result_type want_rsp;
   point_rec_type     sent_points[$];

   always #2 clock = ~clock;

   function automatic int unsigned bucket_of(coord_type x, coord_type y);
      longint      xi;
      longint      yi;
      longint      s;
      longint      t;
      logic [31:0] key;
      logic [63:0] mix;
      // signed division truncates toward zero, as the integer part requires
      xi = longint'(x / 65536);
      yi = longint'(y / 65536);
      s = xi + yi;
      t = (s * (s + 1)) / 2;
      key = 32'(yi + t);
      mix = 64'(key) * 64'(GOLDEN_Q32);
      mix = 64'(mix[31:0]) * 64'(cur_buckets);
      return mix[63:32];
   endfunction

   function automatic lookup_result_type find_or_insert(coord_type x, coord_type y);
      lookup_result_type res;
      int unsigned  b;
      int unsigned  link;
      int unsigned  n;
      res = '0;
      b = bucket_of(x, y);
      link = tbl_head[b];
      while (link != 0) begin
         if (tbl_x[link-1] == x && tbl_y[link-1] == y) begin
            res.idx   = out_idx_type'(link - 1);
            res.found = 1'b1;
            return res;
         end
         link = tbl_link[link-1];
      end
      if (tbl_count >= CAPACITY) begin
         res.full = 1'b1;
         return res;
      end
      n = tbl_count;
      tbl_x[n]    = x;
      tbl_y[n]    = y;
      tbl_link[n] = tbl_head[b];
      tbl_head[b] = n + 1;
      tbl_count   = n + 1;
      res.idx     = out_idx_type'(n);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      if (errors <= 40)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // entered and left at a falling edge; valid stays up so the next
   // transaction can follow without a gap
   task automatic send_point(input coord_type x, input coord_type y);
      if (!calm && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(24, 1)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.x_coord <= x;
      req_ch.y_coord <= y;
      do @(posedge clock); while (!req_ch.ready);
      expected_lookups.push_back(find_or_insert(x, y));
      sent_points.push_back('{x, y});
      @(negedge clock);
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (expected_lookups.size() != 0);
   endtask

   task automatic write_bucket_count(input bcnt_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (value == 0)
         cur_buckets = 1;
      else if (value > MAX_BUCKETS)
         cur_buckets = MAX_BUCKETS;
      else
         cur_buckets = 32'(value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic pick_point(output coord_type x, output coord_type y);
      coord_type   corners [6];
      int unsigned mode;
      int unsigned k;
      int          iv;
      corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'hFFFF_0000};
      mode = $urandom_range(99);
      if (mode < 25 && sent_points.size() > 0) begin
         k = $urandom_range(sent_points.size() - 1);
         x = sent_points[k].x;
         y = sent_points[k].y;
         // near miss: differs only in a fraction bit of y, so often the same key
         if (mode < 5) y[$urandom_range(15)] ^= 1'b1;
      end else if (mode < 55) begin
         x = $urandom;
         y = $urandom;
      end else if (mode < 85) begin
         // small integer parts crowd a few keys, so chains grow long
         iv = int'($urandom_range(8)) - 4;
         x = {iv[15:0], 16'($urandom)};
         iv = int'($urandom_range(8)) - 4;
         y = {iv[15:0], 16'($urandom)};
      end else begin
         x = corners[$urandom_range(5)];
         y = $urandom;
         if ($urandom_range(1)) begin
            y = x;
            x = $urandom;
         end
      end
   endtask

   task automatic test_extremes;
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      // same key as the origin: integer parts truncate to zero, or (-1, 0) pairs to key 0
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h0000_FFFF, 32'h0000_0000);
      send_point(32'hFFFF_8000, 32'h0000_0001);
      send_point(32'h0000_0001, 32'h0000_0000);
      send_point(32'hFFFF_0000, 32'h0000_0000);
      // negative integer parts (the first pair gives a negative key)
      send_point(32'h000A_0000, 32'hFFF6_0000);
      send_point(32'hFFFD_0000, 32'hFFFE_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();
   endtask

   task automatic test_single_bucket;
      // a zero write selects one bucket; older entries may now be missed
      write_bucket_count('0);
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h0001_8000, 32'h0002_4000);
      send_point(32'h0001_C000, 32'h0002_4000);
      send_point(32'h0001_8000, 32'h0002_4000);
      send_point(32'h8000_0000, 32'h8000_0000);
      drain();
   endtask

   task automatic test_bucket_cap;
      write_bucket_count('1);
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h0001_8000, 32'h0002_4000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      drain();
   endtask

   task automatic test_random_mix;
      bcnt_type  counts [5];
      coord_type x;
      coord_type y;
      counts = '{11'd7, 11'd1024, bcnt_type'($urandom_range(1023, 64)), 11'd2047,
                 bcnt_type'($urandom_range(2047, 256))};
      foreach (counts[p]) begin
         write_bucket_count(counts[p]);
         if (p == 1) calm <= 1'b1;
         repeat (300) begin
            pick_point(x, y);
            send_point(x, y);
         end
         drain();
         calm <= 1'b0;
      end
   endtask

   task automatic test_store_full;
      coord_type x;
      coord_type y;
      while (tbl_count < CAPACITY)
         send_point($urandom, $urandom);
      // points stored under the current bucket count are found, others are turned away
      repeat (200) begin
         pick_point(x, y);
         send_point(x, y);
      end
      drain();
   endtask

   always @(negedge clock)
      rsp_ch.ready <= calm || ($urandom_range(99) >= 32);

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_lookups.size() == 0) begin
            report_mismatch("unexpected transaction", longint'(rsp_ch.entry_index), 0);
         end else begin
            want_rsp = expected_lookups.pop_front();
            if (rsp_ch.entry_index !== want_rsp.idx)
               report_mismatch("entry_index", longint'(rsp_ch.entry_index),
                               longint'(want_rsp.idx));
            if (rsp_ch.found !== want_rsp.found)
               report_mismatch("found", longint'(rsp_ch.found), longint'(want_rsp.found));
            if (rsp_ch.full_res !== want_rsp.full)
               report_mismatch("full_res", longint'(rsp_ch.full_res),
                               longint'(want_rsp.full));
         end
      end
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.x_coord = '0;
      req_ch.y_coord = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.data    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_single_bucket();
      test_bucket_cap();
      test_random_mix();
      test_store_full();
      repeat (24) @(negedge clock);
      if (expected_lookups.size() != 0)
         report_mismatch("missing transactions", 0, longint'(expected_lookups.size()));
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
